>>> rtl/cia_pkg.sv
`default_nettype none
package cia_pkg;

  // Operation selector carried in the input tuser
  typedef enum logic [1:0] {
    OP_PROCESS    = 2'd0,
    OP_SET_TARGET = 2'd1,
    OP_START_HOME = 2'd2,
    OP_STOP       = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_POS_WINDOW    = 2'd0,
    CFG_SETTLE_TMO    = 2'd1,
    CFG_STABLE_NEEDED = 2'd2,
    CFG_ENABLE_DELAY  = 2'd3
  } cfg_idx_e;

  // Homing outcome codes
  typedef enum logic [1:0] {
    HM_RES_NONE    = 2'd0,
    HM_RES_OK      = 2'd1,
    HM_RES_TIMEOUT = 2'd2,
    HM_RES_ERROR   = 2'd3
  } hm_res_e;

  localparam logic [15:0] SW_MASK_A      = 16'h004F;
  localparam logic [15:0] SW_MASK_B      = 16'h006F;
  localparam logic [15:0] ST_SW_DISABLED = 16'h0040;
  localparam logic [15:0] ST_READY       = 16'h0021;
  localparam logic [15:0] ST_SWITCHED_ON = 16'h0023;
  localparam logic [15:0] ST_OP_ENABLED  = 16'h0027;
  localparam logic [15:0] CMD_SHUTDOWN   = 16'h0006;
  localparam logic [15:0] CMD_SWITCH_ON  = 16'h0007;
  localparam logic [15:0] CMD_ENABLE_OP  = 16'h000F;
  localparam logic [15:0] KEEP_HIGH      = 16'h00F0;
  localparam logic [15:0] LOW_NIBBLE     = 16'h000F;
  localparam logic [15:0] BIT_START      = 16'h0010;
  localparam logic [15:0] BIT_RELATIVE   = 16'h0040;
  localparam logic [15:0] BIT_ACK        = 16'h1000;
  localparam logic [15:0] BIT_ATTAINED   = 16'h1000;
  localparam logic [15:0] BIT_HM_ERROR   = 16'h2000;
  localparam logic [7:0]  MODE_PP        = 8'd1;
  localparam logic [7:0]  MODE_HM        = 8'd6;

  localparam logic [31:0] POS_WINDOW_RST    = 32'd100;
  localparam logic [15:0] SETTLE_TMO_RST    = 16'd5000;
  localparam logic [15:0] STABLE_NEEDED_RST = 16'd50;
  localparam logic [6:0]  ENABLE_DELAY_RST  = 7'd20;

  // Homing bookkeeping kept across cycles
  typedef struct packed {
    logic        pending;
    logic        settling;
    logic [15:0] countdown;
    logic [15:0] stable;
  } hm_state_t;

  typedef struct packed {
    logic [31:0] pos_window;
    logic [15:0] settle_tmo;
    logic [15:0] stable_needed;
  } hm_cfg_t;

endpackage
`default_nettype wire

>>> rtl/cia_homing.sv
`default_nettype none
module cia_homing (
  input  var cia_pkg::hm_state_t state_i,
  input  var cia_pkg::hm_cfg_t   cfg_i,
  input  wire logic [15:0]       ctrl_i,
  input  wire logic [15:0]       status_i,
  input  wire logic [31:0]       pos_i,
  output cia_pkg::hm_state_t     state_o,
  output logic [15:0]            ctrl_o,
  output cia_pkg::hm_res_e       result_o
);
  import cia_pkg::*;

  logic        started;
  logic [31:0] mag;

  assign started = (ctrl_i & BIT_START) != 16'h0000;
  assign mag     = pos_i[31] ? (32'd0 - pos_i) : pos_i;

  always_comb begin
    state_o  = state_i;
    ctrl_o   = ctrl_i;
    result_o = HM_RES_NONE;
    if ((status_i & BIT_HM_ERROR) != 16'h0000) begin
      ctrl_o           = ctrl_i & ~BIT_START;
      state_o.pending  = 1'b0;
      state_o.settling = 1'b0;
      result_o         = HM_RES_ERROR;
    end else if (!started && state_i.pending) begin
      ctrl_o           = ctrl_i | BIT_START;
      state_o.pending  = 1'b0;
      state_o.settling = 1'b0;
    end else if (started) begin
      // arm the settle check on the first attained cycle
      if (((status_i & BIT_ATTAINED) != 16'h0000) && !state_i.settling) begin
        state_o.settling  = 1'b1;
        state_o.countdown = cfg_i.settle_tmo;
        state_o.stable    = 16'd0;
      end
      if (state_o.settling) begin
        if (state_o.countdown != 16'd0) begin
          state_o.countdown = state_o.countdown - 16'd1;
        end
        if (mag <= cfg_i.pos_window) begin
          if (state_o.stable != 16'hFFFF) begin
            state_o.stable = state_o.stable + 16'd1;
          end
        end else begin
          state_o.stable = 16'd0;
        end
        if (state_o.stable >= cfg_i.stable_needed) begin
          ctrl_o           = ctrl_i & ~BIT_START;
          state_o.settling = 1'b0;
          result_o         = HM_RES_OK;
        end else if (state_o.countdown == 16'd0) begin
          ctrl_o           = ctrl_i & ~BIT_START;
          state_o.settling = 1'b0;
          result_o         = HM_RES_TIMEOUT;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/cia402_drive_enable_and_homing_core.sv
`default_nettype none
// Latency: a word accepted on the slave side passes the input register and then the result register to the master side.
// Throughput: one word per cycle while the master side does not stall; the state update for a word is
//   combinational between the input register and the result register.
// Reset: rst_ni clears all drive state, both valid flags and loads the register defaults
//   (window 100, timeout 5000, stable count 50, enable delay 20).
module cia402_drive_enable_and_homing_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  // slave side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: [0] link_operational, [16:1] drive status, [24:17] mode_display,
  //        [56:25] position feedback, [88:57] new_target, [95:89] zero
  input  wire logic [95:0] s_axis_tdata,
  // tuser: [1:0] operation
  input  wire logic [1:0]  s_axis_tuser,
  // master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: [15:0] drive control, [23:16] mode_command, [55:24] commanded target,
  //        [57:56] homing_result, [63:58] zero
  output logic [63:0]      m_axis_tdata
);
  import cia_pkg::*;

  // configuration
  logic [31:0] pos_window_q;
  logic [15:0] settle_tmo_q;
  logic [15:0] stable_needed_q;
  logic [6:0]  enable_delay_q;

  // input register
  logic        in_valid_q;
  logic [1:0]  in_op_q;
  logic        in_link_q;
  logic [15:0] in_sw_q;
  logic [7:0]  in_mode_q;
  logic [31:0] in_pos_q;
  logic [31:0] in_tgt_q;

  // drive state
  logic [15:0] ctrl_q, ctrl_d;
  logic [7:0]  mode_q, mode_d;
  logic [31:0] target_q, target_d;
  logic        sp_pend_q, sp_pend_d;
  logic [7:0]  wait_q, wait_d;
  hm_state_t   hm_q, hm_d;

  // result register
  logic        out_valid_q;
  logic [63:0] out_data_q;

  hm_cfg_t     hm_cfg;
  hm_state_t   hm_next;
  logic [15:0] hm_ctrl;
  hm_res_e     hm_res;
  hm_res_e     result;
  logic [15:0] high;
  logic        out_free;
  logic        advance;

  // The result slot frees when empty or being taken; the input slot then drains into it.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign hm_cfg.pos_window    = pos_window_q;
  assign hm_cfg.settle_tmo    = settle_tmo_q;
  assign hm_cfg.stable_needed = stable_needed_q;

  cia_homing u_homing (
    .state_i  (hm_q),
    .cfg_i    (hm_cfg),
    .ctrl_i   (ctrl_q),
    .status_i (in_sw_q),
    .pos_i    (in_pos_q),
    .state_o  (hm_next),
    .ctrl_o   (hm_ctrl),
    .result_o (hm_res)
  );

  // Only bits 7..4 of the control word survive a state command of the enable sequence.
  assign high = ctrl_q & KEEP_HIGH;

  always_comb begin
    ctrl_d    = ctrl_q;
    mode_d    = mode_q;
    target_d  = target_q;
    sp_pend_d = sp_pend_q;
    wait_d    = wait_q;
    hm_d      = hm_q;
    result    = HM_RES_NONE;
    case (op_e'(in_op_q))
      OP_SET_TARGET: begin
        mode_d    = MODE_PP;
        target_d  = in_tgt_q;
        ctrl_d    = ctrl_q & ~BIT_RELATIVE;
        sp_pend_d = 1'b1;
      end
      OP_START_HOME: begin
        mode_d     = MODE_HM;
        ctrl_d     = ctrl_q & ~BIT_RELATIVE;
        hm_d.pending = 1'b1;
      end
      OP_STOP: begin
        ctrl_d = CMD_SHUTDOWN;
      end
      default: begin
        if ((in_sw_q & SW_MASK_B) == ST_OP_ENABLED) begin
          if (in_mode_q == MODE_PP) begin
            // new-setpoint handshake: raise start, drop it on acknowledge
            if ((ctrl_q & BIT_START) != 16'h0000) begin
              if ((in_sw_q & BIT_ACK) != 16'h0000) begin
                ctrl_d = ctrl_q & ~BIT_START;
              end
            end else if (sp_pend_q) begin
              ctrl_d    = ctrl_q | BIT_START;
              sp_pend_d = 1'b0;
            end
          end else if (in_mode_q == MODE_HM) begin
            ctrl_d = hm_ctrl;
            hm_d   = hm_next;
            result = hm_res;
          end
        end else if (in_link_q) begin
          // enable sequence, frozen while the link is down
          if (wait_q != 8'd0) begin
            wait_d = wait_q - 8'd1;
          end else if ((in_sw_q & SW_MASK_A) == ST_SW_DISABLED) begin
            ctrl_d = high | CMD_SHUTDOWN;
            wait_d = {1'b0, enable_delay_q};
          end else if ((in_sw_q & SW_MASK_B) == ST_READY) begin
            ctrl_d = high | CMD_SWITCH_ON;
            wait_d = {1'b0, enable_delay_q};
          end else if ((in_sw_q & SW_MASK_B) == ST_SWITCHED_ON) begin
            // a second enable attempt from switched-on drops back to shutdown
            if ((ctrl_q & LOW_NIBBLE) == CMD_ENABLE_OP) begin
              ctrl_d = high | CMD_SHUTDOWN;
            end else begin
              ctrl_d = high | CMD_ENABLE_OP;
            end
            wait_d = {enable_delay_q, 1'b0};
          end
        end
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_window_q    <= POS_WINDOW_RST;
      settle_tmo_q    <= SETTLE_TMO_RST;
      stable_needed_q <= STABLE_NEEDED_RST;
      enable_delay_q  <= ENABLE_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POS_WINDOW:    pos_window_q    <= cfg_wdata_i;
        CFG_SETTLE_TMO:    settle_tmo_q    <= cfg_wdata_i[15:0];
        CFG_STABLE_NEEDED: stable_needed_q <= cfg_wdata_i[15:0];
        CFG_ENABLE_DELAY:  enable_delay_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // input register: hold a word until the result slot can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_link_q <= s_axis_tdata[0];
      in_sw_q   <= s_axis_tdata[16:1];
      in_mode_q <= s_axis_tdata[24:17];
      in_pos_q  <= s_axis_tdata[56:25];
      in_tgt_q  <= s_axis_tdata[88:57];
    end
  end

  // drive state and result register: advance once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= 16'd0;
      mode_q      <= 8'd0;
      target_q    <= 32'd0;
      sp_pend_q   <= 1'b0;
      wait_q      <= 8'd0;
      hm_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        ctrl_q    <= ctrl_d;
        mode_q    <= mode_d;
        target_q  <= target_d;
        sp_pend_q <= sp_pend_d;
        wait_q    <= wait_d;
        hm_q      <= hm_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'd0, result, target_d, mode_d, ctrl_d};
    end
  end

endmodule
`default_nettype wire
